@@ design/bcd_time_of_day_clock_alarm_top_macros.svh @@
// assertion macros for the time-of-day clock block
`ifndef BCD_TIME_OF_DAY_CLOCK_ALARM_TOP_MACROS_SVH
`define BCD_TIME_OF_DAY_CLOCK_ALARM_TOP_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define BCDTOD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcdtod same-cycle check failed");

// next-cycle implication under synchronous active-low reset
`define BCDTOD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcdtod next-cycle check failed");

`endif

@@ design/bcdtod_pkg.sv @@
// types and constants shared by the time-of-day clock modules
`timescale 1ns / 1ps

package bcdtod_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [1:0] IDX_TENTHS  = 2'd0;
    localparam logic [1:0] IDX_SECONDS = 2'd1;
    localparam logic [1:0] IDX_MINUTES = 2'd2;
    localparam logic [1:0] IDX_HOURS   = 2'd3;

    localparam logic CFG_FIFTY_HZ    = 1'b0;
    localparam logic CFG_ALARM_WRITE = 1'b1;

    localparam logic [7:0] TENTHS_MASK = 8'h0f;
    localparam logic [7:0] HOURS_MASK  = 8'h9f;
    localparam logic [7:0] BYTE_MASK   = 8'h7f;
    localparam logic [7:0] PM_FLIP     = 8'h80;
    localparam logic [4:0] HOURS_TWELVE = 5'h12;

    localparam logic [31:0] HOUR_ONE = 32'h0100_0000;

    localparam logic [2:0] PRESCALE_50 = 3'd5;
    localparam logic [2:0] PRESCALE_60 = 3'd6;

    typedef logic [3:0][7:0] tod_t;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] reg_index;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       alarm_irq;
    } result_t;

    typedef struct packed {
        logic fifty_hz;
        logic alarm_write;
    } cfg_t;

endpackage

@@ design/bcdtod_inc.sv @@
// bcd increment of the time word by one tenth with carries through the hours
`timescale 1ns / 1ps

module bcdtod_inc (
    input  bcdtod_pkg::tod_t tod_in,
    output bcdtod_pkg::tod_t tod_out
);

    logic [3:0] ts;
    logic [3:0] sl;
    logic [2:0] sh;
    logic [3:0] ml;
    logic [2:0] mh;
    logic [3:0] hl;
    logic       hh;
    logic       pm;

    always_comb begin
        ts = tod_in[0][3:0] + 4'd1;
        sl = tod_in[1][3:0];
        sh = tod_in[1][6:4];
        ml = tod_in[2][3:0];
        mh = tod_in[2][6:4];
        hl = tod_in[3][3:0];
        hh = tod_in[3][4];
        pm = tod_in[3][7];
        if (ts == 4'd10) begin
            ts = 4'd0;
            sl = sl + 4'd1;
            if (sl == 4'd10) begin
                sl = 4'd0;
                sh = sh + 3'd1;
                if (sh == 3'd6) begin
                    sh = 3'd0;
                    ml = ml + 4'd1;
                    if (ml == 4'd10) begin
                        ml = 4'd0;
                        mh = mh + 3'd1;
                        if (mh == 3'd6) begin
                            mh = 3'd0;
                            hl = hl + 4'd1;
                            if (hh) begin
                                if (hl == 4'd2) begin
                                    pm = ~pm;
                                end
                                if (hl == 4'd3) begin
                                    hl = 4'd1;
                                    hh = 1'b0;
                                end
                            end else if (hl == 4'd10) begin
                                hl = 4'd0;
                                hh = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        tod_out[0] = {4'd0, ts};
        tod_out[1] = {1'b0, sh, sl};
        tod_out[2] = {1'b0, mh, ml};
        tod_out[3] = {pm, 2'b00, hh, hl};
    end

endmodule

@@ design/bcdtod_state.sv @@
// clock, alarm, read latch and prescaler state with per-beat command execution
`timescale 1ns / 1ps

module bcdtod_state (
    input  logic                aclk,
    input  logic                aresetn,
    input  bcdtod_pkg::cfg_t    cfg,
    input  logic                exec,
    input  bcdtod_pkg::item_t   item,
    output bcdtod_pkg::result_t result
);

    bcdtod_pkg::tod_t clock_reg, clock_next;
    bcdtod_pkg::tod_t latch_reg, latch_next;
    bcdtod_pkg::tod_t alarm_reg, alarm_next;
    logic             frozen_reg, frozen_next;
    logic             running_reg, running_next;
    logic [2:0]       prescale_reg, prescale_next;

    bcdtod_pkg::tod_t tod_step;
    bcdtod_pkg::tod_t latch_view;
    bcdtod_pkg::tod_t new_word;
    logic [2:0]       pc_inc;
    logic [2:0]       pc_cmp;
    logic [7:0]       wr_byte;
    logic             changed;

    bcdtod_inc u_inc (
        .tod_in  (clock_reg),
        .tod_out (tod_step)
    );

    always_comb begin
        clock_next    = clock_reg;
        latch_next    = latch_reg;
        alarm_next    = alarm_reg;
        frozen_next   = frozen_reg;
        running_next  = running_reg;
        prescale_next = prescale_reg;
        result        = '0;

        pc_inc     = prescale_reg + 3'd1;
        pc_cmp     = cfg.fifty_hz ? bcdtod_pkg::PRESCALE_50 : bcdtod_pkg::PRESCALE_60;
        latch_view = frozen_reg ? latch_reg : clock_reg;

        case (item.reg_index)
            bcdtod_pkg::IDX_TENTHS: begin
                wr_byte = item.write_data & bcdtod_pkg::TENTHS_MASK;
            end
            bcdtod_pkg::IDX_HOURS: begin
                wr_byte = item.write_data & bcdtod_pkg::HOURS_MASK;
                if (wr_byte[4:0] == bcdtod_pkg::HOURS_TWELVE && !cfg.alarm_write) begin
                    wr_byte = wr_byte ^ bcdtod_pkg::PM_FLIP;
                end
            end
            default: begin
                wr_byte = item.write_data & bcdtod_pkg::BYTE_MASK;
            end
        endcase

        new_word = cfg.alarm_write ? alarm_reg : clock_reg;
        changed  = wr_byte != new_word[item.reg_index];
        new_word[item.reg_index] = wr_byte;

        case (item.command)
            bcdtod_pkg::CMD_TICK: begin
                if (running_reg) begin
                    if (pc_inc == pc_cmp) begin
                        prescale_next    = 3'd0;
                        clock_next       = tod_step;
                        result.alarm_irq = tod_step == alarm_reg;
                    end else if (pc_inc > pc_cmp) begin
                        prescale_next = 3'd0;
                    end else begin
                        prescale_next = pc_inc;
                    end
                end
            end
            bcdtod_pkg::CMD_READ: begin
                latch_next       = latch_view;
                result.read_data = latch_view[item.reg_index];
                if (item.reg_index == bcdtod_pkg::IDX_TENTHS) begin
                    frozen_next = 1'b0;
                end else if (item.reg_index == bcdtod_pkg::IDX_HOURS) begin
                    frozen_next = 1'b1;
                end
            end
            bcdtod_pkg::CMD_WRITE: begin
                if (cfg.alarm_write) begin
                    alarm_next       = new_word;
                    result.alarm_irq = changed && (clock_reg == new_word);
                end else begin
                    clock_next       = new_word;
                    result.alarm_irq = changed && (new_word == alarm_reg);
                    if (item.reg_index == bcdtod_pkg::IDX_TENTHS) begin
                        if (!running_reg) begin
                            prescale_next = 3'd0;
                        end
                        running_next = 1'b1;
                    end else if (item.reg_index == bcdtod_pkg::IDX_HOURS) begin
                        running_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg    <= bcdtod_pkg::HOUR_ONE;
            latch_reg    <= bcdtod_pkg::HOUR_ONE;
            alarm_reg    <= '0;
            frozen_reg   <= 1'b0;
            running_reg  <= 1'b0;
            prescale_reg <= 3'd0;
        end else if (exec) begin
            clock_reg    <= clock_next;
            latch_reg    <= latch_next;
            alarm_reg    <= alarm_next;
            frozen_reg   <= frozen_next;
            running_reg  <= running_next;
            prescale_reg <= prescale_next;
        end
    end

endmodule

@@ design/bcd_time_of_day_clock_alarm_top.sv @@
// top level of the bcd time-of-day clock with alarm
//
//  channel  | direction | ports                                  | beat
//  ---------+-----------+----------------------------------------+-----------------------------
//  s_       | in        | s_command, s_reg_index, s_write_data   | one tick, read or write
//  m_       | out       | m_read_data, m_alarm_irq               | one result per input beat
//  cfg_     | in        | cfg_index, cfg_data                    | one register write
//
// an input beat lands in the input register, is executed against the clock state
// by the combinational bcd step of the state unit and its result goes to the output
// register; one beat per cycle sustained while the output is not stalled.
// reset brings the clock to 1 AM stopped with the alarm at zero; no clearing pass.
// a stalled output holds the executing beat in the input register and drops s_ready.
`timescale 1ns / 1ps
`include "bcd_time_of_day_clock_alarm_top_macros.svh"

module bcd_time_of_day_clock_alarm_top (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [1:0] s_reg_index,
    input  logic [7:0] s_write_data,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_alarm_irq,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data
);

    bcdtod_pkg::cfg_t    cfg_reg;
    bcdtod_pkg::item_t   in_item_reg;
    logic                in_valid_reg;
    bcdtod_pkg::result_t out_res_reg;
    logic                out_valid_reg;
    bcdtod_pkg::result_t res;
    logic                advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bcdtod_pkg::CFG_FIFTY_HZ: begin
                    cfg_reg.fifty_hz <= cfg_data;
                end
                bcdtod_pkg::CFG_ALARM_WRITE: begin
                    cfg_reg.alarm_write <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command    <= s_command;
            in_item_reg.reg_index  <= s_reg_index;
            in_item_reg.write_data <= s_write_data;
        end
    end

    bcdtod_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .exec    (advance),
        .item    (in_item_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = out_res_reg.read_data;
    assign m_alarm_irq = out_res_reg.alarm_irq;

    `BCDTOD_ASSERT_SAME(a_not_ready_means_full, aclk, aresetn, !s_ready, in_valid_reg)
    `BCDTOD_ASSERT_NEXT(a_exec_fills_output, aclk, aresetn, advance, m_valid)
    `BCDTOD_ASSERT_NEXT(a_read_no_irq, aclk, aresetn,
        advance && in_item_reg.command == bcdtod_pkg::CMD_READ, !m_alarm_irq)
    `BCDTOD_ASSERT_NEXT(a_nonread_zero_data, aclk, aresetn,
        advance && in_item_reg.command != bcdtod_pkg::CMD_READ, m_read_data == 8'd0)

endmodule
